FILE: rtl/ps_adpcm_block_decoder_top_macros.svh
`ifndef PS_ADPCM_BLOCK_DECODER_TOP_MACROS_SVH
`define PS_ADPCM_BLOCK_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSADPCM_ASSERT_NOW(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PSADPCM_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

`endif

FILE: rtl/psadpcm_pkg.sv
package psadpcm_pkg;

  typedef enum logic [1:0] {
    ST_SAMPLE = 2'd0,
    ST_END    = 2'd1,
    ST_BAD    = 2'd2
  } status_t;

  typedef logic signed [15:0] sample_t;

  localparam logic [3:0] MaxShift  = 4'd12;
  localparam logic [3:0] MaxFilter = 4'd4;
  localparam logic [7:0] EndFlag   = 8'd7;

  function automatic logic signed [7:0] coef_newest(input logic [2:0] filter);
    case (filter)
      3'd1:    coef_newest = 8'sd60;
      3'd2:    coef_newest = 8'sd115;
      3'd3:    coef_newest = 8'sd98;
      3'd4:    coef_newest = 8'sd122;
      default: coef_newest = 8'sd0;
    endcase
  endfunction

  function automatic logic signed [7:0] coef_older(input logic [2:0] filter);
    case (filter)
      3'd2:    coef_older = -8'sd52;
      3'd3:    coef_older = -8'sd55;
      3'd4:    coef_older = -8'sd60;
      default: coef_older = 8'sd0;
    endcase
  endfunction

  // one 4-bit code to one saturated sample
  function automatic sample_t decode_nibble(input logic [3:0] code, input logic [3:0] shift,
                                            input logic [2:0] filter, input sample_t hist_new,
                                            input sample_t hist_old);
    logic signed [15:0] v;
    logic signed [23:0] p_new;
    logic signed [23:0] p_old;
    logic signed [24:0] pred;
    logic signed [24:0] pred_adj;
    logic signed [18:0] quot;
    logic signed [19:0] sum;
    v        = $signed({code, 12'b0}) >>> shift;
    p_new    = hist_new * coef_newest(filter);
    p_old    = hist_old * coef_older(filter);
    pred     = 25'(p_new) + 25'(p_old) + 25'sd32;
    // truncate toward zero
    pred_adj = pred[24] ? (pred + 25'sd63) : pred;
    quot     = 19'(pred_adj >>> 6);
    sum      = 20'(v) + 20'(quot);
    if (sum > 20'sd32767) begin
      decode_nibble = 16'sh7fff;
    end else if (sum < -20'sd32768) begin
      decode_nibble = 16'sh8000;
    end else begin
      decode_nibble = sum[15:0];
    end
  endfunction

endpackage

FILE: rtl/ps_adpcm_block_decoder_top.sv
// Decodes PlayStation SPU ADPCM from a byte stream of 16-byte blocks. A data byte gives two
// samples, low nibble first; header and flags bytes give at most one status beat (end flag or
// bad header). The two samples of a byte share one predictor unit, so a data byte is held
// until both of its samples have been issued. Results pass through an
// output register, so the next byte is taken while a result waits. A byte with start_stream
// high clears the prediction history and block position before it is decoded.
`include "ps_adpcm_block_decoder_top_macros.svh"

module ps_adpcm_block_decoder_top
  import psadpcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] sample,
  output logic [1:0]  status,
  output logic        last
);

  // input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_start;
  logic       phase;

  // block state
  logic [3:0] pos;
  logic [3:0] shift;
  logic [2:0] filter;
  sample_t    hist_new;
  sample_t    hist_old;
  logic       ended;
  logic       skip;

  logic [3:0] pos_next;
  logic [3:0] shift_next;
  logic [2:0] filter_next;
  sample_t    hist_new_next;
  sample_t    hist_old_next;
  logic       ended_next;
  logic       skip_next;
  logic       phase_next;

  logic       emit;
  logic       pop;
  logic       out_free;
  logic       advance;
  sample_t    res_sample;
  status_t    res_status;
  logic       res_last;
  sample_t    dec;
  logic [3:0] dec_code;

  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && (!emit || out_free);
  assign in_stall = hold_valid && !(advance && pop);

  assign dec_code = phase ? hold_byte[7:4] : hold_byte[3:0];

  always_comb begin
    logic       clr;
    logic [3:0] p;
    clr           = !phase && hold_start;
    pos_next      = clr ? 4'd0 : pos;
    shift_next    = clr ? 4'd0 : shift;
    filter_next   = clr ? 3'd0 : filter;
    hist_new_next = clr ? 16'sd0 : hist_new;
    hist_old_next = clr ? 16'sd0 : hist_old;
    ended_next    = clr ? 1'b0 : ended;
    skip_next     = clr ? 1'b0 : skip;
    phase_next    = 1'b0;
    emit          = 1'b0;
    pop           = 1'b1;
    res_sample    = 16'sd0;
    res_status    = ST_SAMPLE;
    res_last      = 1'b1;
    p             = pos_next;
    dec           = decode_nibble(dec_code, shift_next, filter_next, hist_new_next,
                                  hist_old_next);
    if (phase) begin
      emit          = 1'b1;
      res_sample    = dec;
      hist_old_next = hist_new;
      hist_new_next = dec;
    end else if (!ended_next) begin
      pos_next = p + 4'd1;
      if (p == 4'd0) begin
        shift_next  = hold_byte[3:0];
        filter_next = hold_byte[6:4];
        skip_next   = (hold_byte[3:0] > MaxShift) || (hold_byte[7:4] > MaxFilter);
        if (skip_next) begin
          emit       = 1'b1;
          res_status = ST_BAD;
        end
      end else if (skip_next) begin
        if (pos_next == 4'd0) begin
          skip_next = 1'b0;
        end
      end else if (p == 4'd1) begin
        if (hold_byte == EndFlag) begin
          ended_next = 1'b1;
          pos_next   = 4'd0;
          emit       = 1'b1;
          res_status = ST_END;
        end
      end else begin
        emit          = 1'b1;
        pop           = 1'b0;
        phase_next    = 1'b1;
        res_sample    = dec;
        res_last      = 1'b0;
        hist_old_next = hist_new_next;
        hist_new_next = dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= 1'b0;
      pos        <= 4'd0;
      shift      <= 4'd0;
      filter     <= 3'd0;
      hist_new   <= 16'sd0;
      hist_old   <= 16'sd0;
      ended      <= 1'b0;
      skip       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hold_valid <= 1'b1;
        hold_byte  <= data_byte;
        hold_start <= start_stream;
      end else if (advance && pop) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        phase    <= phase_next;
        pos      <= pos_next;
        shift    <= shift_next;
        filter   <= filter_next;
        hist_new <= hist_new_next;
        hist_old <= hist_old_next;
        ended    <= ended_next;
        skip     <= skip_next;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
        sample    <= res_sample;
        status    <= res_status;
        last      <= res_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PSADPCM_ASSERT_NOW(a_phase_holds_byte, phase, hold_valid, "second sample without a byte")
  `PSADPCM_ASSERT_NOW(a_status_zero_sample, out_valid && status != ST_SAMPLE, sample == 16'sd0,
                      "status beat carries a nonzero sample")
  `PSADPCM_ASSERT_NEXT(a_second_is_last, phase && advance,
                       out_valid && last && status == ST_SAMPLE, "second sample not last")
  `PSADPCM_ASSERT_NEXT(a_end_sets_ended, advance && emit && res_status == ST_END,
                       ended && pos == 4'd0, "end flag did not stop the stream")

endmodule

FILE: tb/ps_adpcm_block_decoder_top_test.sv
module ps_adpcm_block_decoder_top_test;
  import psadpcm_pkg::*;

  typedef struct packed {
    logic signed [15:0] sample;
    status_t            status;
    logic               last;
  } adpcm_beat_t;

  class adpcm_scoreboard;
    logic [3:0] byte_pos;
    logic [3:0] shift;
    logic [2:0] filter;
    int         hist_new;
    int         hist_old;
    bit         ended;
    bit         skipping;
    int         recent_gain [8] = '{0, 60, 115, 98, 122, 0, 0, 0};
    int         prior_gain [8] = '{0, 0, -52, -55, -60, 0, 0, 0};
    adpcm_beat_t expected[$];
    int         failures;

    function new();
      clear_stream();
      failures = 0;
    endfunction

    function void clear_stream();
      byte_pos = 4'd0;
      shift    = 4'd0;
      filter   = 3'd0;
      hist_new = 0;
      hist_old = 0;
      ended    = 1'b0;
      skipping = 1'b0;
    endfunction

    function int predict_sample(logic [3:0] code);
      int v;
      int pred;
      v = (code >= 4'd8) ? int'(code) - 16 : int'(code);
      v = (v * 4096) >>> shift;
      pred = hist_new * recent_gain[filter] + hist_old * prior_gain[filter] + 32;
      v = v + pred / 64;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      hist_old = hist_new;
      hist_new = v;
      return v;
    endfunction

    function void push_beat(int s, status_t st, logic l);
      adpcm_beat_t beat;
      beat.sample = 16'(s);
      beat.status = st;
      beat.last   = l;
      expected.insert(expected.size(), beat);
    endfunction

    // returns 0 when the byte falls into an ended stream
    function bit note_byte(logic [7:0] b, logic start);
      logic [3:0] pos;
      if (start) clear_stream();
      if (ended) return 1'b0;
      pos = byte_pos;
      byte_pos = pos + 4'd1;
      if (pos == 4'd0) begin
        skipping = 1'b0;
        shift    = b[3:0];
        filter   = b[6:4];
        if (b[3:0] > MaxShift || b[7:4] > MaxFilter) begin
          skipping = 1'b1;
          push_beat(0, ST_BAD, 1'b1);
        end
        return 1'b1;
      end
      if (skipping) begin
        if (byte_pos == 4'd0) skipping = 1'b0;
        return 1'b1;
      end
      if (pos == 4'd1) begin
        if (b == EndFlag) begin
          ended    = 1'b1;
          byte_pos = 4'd0;
          push_beat(0, ST_END, 1'b1);
        end
        return 1'b1;
      end
      push_beat(predict_sample(b[3:0]), ST_SAMPLE, 1'b0);
      push_beat(predict_sample(b[7:4]), ST_SAMPLE, 1'b1);
      return 1'b1;
    endfunction

    function void check_beat(logic signed [15:0] s, logic [1:0] st, logic got_last);
      adpcm_beat_t want;
      if (expected.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected beat: sample %0d status %0d last %0b", s, st, got_last);
        return;
      end
      want = expected.pop_front();
      if (s !== want.sample || st !== want.status || got_last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected sample %0d status %0d last %0b, got %0d %0d %0b",
                   want.sample, want.status, want.last, s, st, got_last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = 8'd0;
  logic start_stream = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] sample;
  logic [1:0] status;
  logic last;

  int idle_pct = 28;
  int stall_pct = 28;
  int fed = 0;
  adpcm_scoreboard sb = new();

  ps_adpcm_block_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .start_stream (start_stream),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample),
    .status       (status),
    .last         (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_beat(sample, status, last);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    start_stream <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_byte(b, start)) fed++;
  endtask

  initial begin
    static logic [8:0] opening [26] = '{
      9'h100, 9'h000, 9'h077, 9'h077, 9'h088, 9'h0ff, 9'h000, 9'h080,
      9'h140, 9'h002, 9'h077, 9'h077, 9'h077, 9'h088, 9'h088, 9'h088,
      9'h14c, 9'h000, 9'h0a5,
      9'h10d, {1'b0, EndFlag}, 9'h150, 9'h1f0,
      9'h100, {1'b0, EndFlag}, 9'h033
    };
    logic [7:0] hdr;
    logic       restart;
    int         j;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);

    // hold off until the decoder has drained
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);

    fed = 0;
    while (fed < 550) begin
      idle_pct  = (fed >= 250 && fed < 350) ? 0 : 28;
      stall_pct = idle_pct;
      restart = sb.ended || ($urandom_range(9) == 0);
      if ($urandom_range(9) == 0) hdr = 8'($urandom_range(255));
      else hdr = {1'b0, 3'($urandom_range(4)), 4'($urandom_range(12))};
      send_byte(hdr, restart);
      send_byte(($urandom_range(19) == 0) ? EndFlag : 8'($urandom_range(255)), 1'b0);
      if (sb.ended) begin
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
      end else begin
        for (j = 0; j < 14; j++) send_byte(8'($urandom), $urandom_range(49) == 0);
      end
    end
    in_valid <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/psadpcm_pkg.sv
rtl/ps_adpcm_block_decoder_top.sv
tb/ps_adpcm_block_decoder_top_test.sv
